// ===== hw/rtl/cae_pkg.sv =====
// ----------------------------------------------------------------------------
// cae_pkg: shared types and constants for the 6502 ALU execute core
// Item structs, decoded operation codes and status flag positions.
// ----------------------------------------------------------------------------
package cae_pkg;

	// status bit positions, N V - B D I Z C from bit 7 down
	localparam logic [2:0] FLAG_C = 3'd0;
	localparam logic [2:0] FLAG_Z = 3'd1;
	localparam logic [2:0] FLAG_I = 3'd2;
	localparam logic [2:0] FLAG_D = 3'd3;
	localparam logic [2:0] FLAG_V = 3'd6;
	localparam logic [2:0] FLAG_N = 3'd7;

	// raw code with no operation behind it; runs as nop
	localparam logic [5:0] OP_CODE_UNUSED = 6'd63;

	typedef enum logic [5:0] {
		OP_LDA   = 6'd0,  OP_LDX   = 6'd1,  OP_LDY   = 6'd2,  OP_EOR   = 6'd3,
		OP_AND   = 6'd4,  OP_ORA   = 6'd5,  OP_ADC   = 6'd6,  OP_SBC   = 6'd7,
		OP_CMP   = 6'd8,  OP_BIT   = 6'd9,  OP_LAX   = 6'd10, OP_NOP   = 6'd11,
		OP_ASL   = 6'd12, OP_LSR   = 6'd13, OP_ROL   = 6'd14, OP_ROR   = 6'd15,
		OP_INC   = 6'd16, OP_DEC   = 6'd17, OP_SLO   = 6'd18, OP_SRE   = 6'd19,
		OP_RLA   = 6'd20, OP_RRA   = 6'd21, OP_ISC   = 6'd22, OP_DCP   = 6'd23,
		OP_STA   = 6'd24, OP_STX   = 6'd25, OP_STY   = 6'd26, OP_SAX   = 6'd27,
		OP_BCC   = 6'd28, OP_BCS   = 6'd29, OP_BEQ   = 6'd30, OP_BMI   = 6'd31,
		OP_BNE   = 6'd32, OP_BPL   = 6'd33, OP_BVC   = 6'd34, OP_BVS   = 6'd35,
		OP_ASL_A = 6'd36, OP_LSR_A = 6'd37, OP_ROL_A = 6'd38, OP_ROR_A = 6'd39,
		OP_CPX   = 6'd40, OP_CPY   = 6'd41, OP_CLC   = 6'd42, OP_CLD   = 6'd43,
		OP_CLI   = 6'd44, OP_CLV   = 6'd45, OP_DEX   = 6'd46, OP_DEY   = 6'd47,
		OP_INX   = 6'd48, OP_INY   = 6'd49, OP_SEC   = 6'd50, OP_SED   = 6'd51,
		OP_SEI   = 6'd52, OP_TAX   = 6'd53, OP_TAY   = 6'd54, OP_TSX   = 6'd55,
		OP_TXA   = 6'd56, OP_TYA   = 6'd57, OP_TXS   = 6'd58, OP_ALR   = 6'd59,
		OP_ANC   = 6'd60, OP_ARR   = 6'd61, OP_AXS   = 6'd62
	} op_t;

	typedef struct packed {
		logic [5:0] operation;
		logic [7:0] operand;
	} cmd_t;

	typedef struct packed {
		logic [7:0] result_byte;
		logic       branch_taken;
		logic [7:0] acc_out;
		logic [7:0] x_out;
		logic [7:0] y_out;
		logic [7:0] status_out;
		logic [7:0] sp_out;
	} rsp_t;

	// decoded item as it sits in the queue
	typedef struct packed {
		op_t        op;
		logic [7:0] operand;
		logic       is_branch;
		logic [2:0] br_flag;
		logic       br_pol;
	} dec_item_t;

	// queue head as seen by the execute side
	typedef struct packed {
		logic      valid;
		dec_item_t item;
	} q_head_t;

endpackage

// ===== hw/rtl/cpu6502_alu_execute_core.sv =====
// ----------------------------------------------------------------------------
// cpu6502_alu_execute_core: 6502 data-operation execute unit, binary only
// Front decodes and queues commands, back executes and registers results.
// ----------------------------------------------------------------------------
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-------------------------------
//   cmd     | in  | cmd_valid / cmd_stall | operation[5:0], operand[7:0]
//   rsp     | out | rsp_valid / rsp_stall | result byte, branch, A X Y P SP
//
// Flow: one item per clock sustained while rsp_stall does not hold the back;
//   a command goes into the queue, then executes into the result register.
// The execute step reads A/X/Y/SP/P and writes them in the same clock, so
//   dependent items follow each other with no bubble.
// Stalls: cmd_stall rises only when the QueueDepth-entry queue is full;
//   the back stage holds while a result waits under rsp_stall.
// Reset: arst_n clears A X Y SP P, queue pointers and count, result valid.
//
module cpu6502_alu_execute_core #(
	parameter int unsigned QueueDepth = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  cae_pkg::cmd_t  cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output cae_pkg::rsp_t  rsp
);

	cae_pkg::q_head_t head;
	logic             pop;

	// decode and buffer
	cae_front #(
		.Depth (QueueDepth)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.pop       (pop),
		.head      (head)
	);

	// register file, ALU and result register
	cae_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// ===== hw/rtl/cae_front.sv =====
// ----------------------------------------------------------------------------
// cae_front: command intake and decode
// Maps raw codes to operations, classifies branches and queues the result.
// ----------------------------------------------------------------------------
module cae_front #(
	parameter int unsigned Depth = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_stall,
	input  cae_pkg::cmd_t     cmd,
	input  logic              pop,
	output cae_pkg::q_head_t  head
);

	localparam int unsigned PtrW = $clog2(Depth);
	localparam int unsigned CntW = $clog2(Depth + 1);

	cae_pkg::dec_item_t dec;
	cae_pkg::dec_item_t queue_q [Depth];
	logic [PtrW-1:0]    wr_ptr_q;
	logic [PtrW-1:0]    rd_ptr_q;
	logic [CntW-1:0]    count_q;
	logic               push;

	// decode
	always_comb begin
		if (cmd.operation == cae_pkg::OP_CODE_UNUSED) begin
			dec.op = cae_pkg::OP_NOP;
		end else begin
			dec.op = cae_pkg::op_t'(cmd.operation);
		end
		dec.operand   = cmd.operand;
		dec.is_branch = 1'b1;
		dec.br_flag   = cae_pkg::FLAG_C;
		dec.br_pol    = 1'b0;
		unique case (dec.op)
			cae_pkg::OP_BCC: begin dec.br_flag = cae_pkg::FLAG_C; dec.br_pol = 1'b0; end
			cae_pkg::OP_BCS: begin dec.br_flag = cae_pkg::FLAG_C; dec.br_pol = 1'b1; end
			cae_pkg::OP_BEQ: begin dec.br_flag = cae_pkg::FLAG_Z; dec.br_pol = 1'b1; end
			cae_pkg::OP_BMI: begin dec.br_flag = cae_pkg::FLAG_N; dec.br_pol = 1'b1; end
			cae_pkg::OP_BNE: begin dec.br_flag = cae_pkg::FLAG_Z; dec.br_pol = 1'b0; end
			cae_pkg::OP_BPL: begin dec.br_flag = cae_pkg::FLAG_N; dec.br_pol = 1'b0; end
			cae_pkg::OP_BVC: begin dec.br_flag = cae_pkg::FLAG_V; dec.br_pol = 1'b0; end
			cae_pkg::OP_BVS: begin dec.br_flag = cae_pkg::FLAG_V; dec.br_pol = 1'b1; end
			default:         dec.is_branch = 1'b0;
		endcase
	end

	assign cmd_stall = (count_q == CntW'(Depth));
	assign push      = cmd_valid && !cmd_stall;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign head.valid = (count_q != '0);
	assign head.item  = queue_q[rd_ptr_q];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(Depth))
		else $error("queue count above depth");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");

	a_count_track: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

endmodule

// ===== hw/rtl/cae_back.sv =====
// ----------------------------------------------------------------------------
// cae_back: execute stage and result register
// Holds A, X, Y, SP, status; runs one queued item per cycle unless stalled.
// ----------------------------------------------------------------------------
module cae_back (
	input  logic              clk,
	input  logic              arst_n,
	input  cae_pkg::q_head_t  head,
	output logic              pop,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output cae_pkg::rsp_t     rsp
);

	logic [7:0] acc_q, x_q, y_q, sp_q, p_q;
	logic [7:0] acc_n, x_n, y_n, sp_n, p_n;
	logic [7:0] res, opnd, t, r;
	logic [9:0] ad;
	logic       zen;
	logic [7:0] zv;
	logic       br;
	logic       cf;
	logic       go;
	logic       rsp_valid_q;
	cae_pkg::rsp_t rsp_q;

	// {V, C, sum}
	function automatic logic [9:0] add_f(input logic [7:0] a, input logic [7:0] b,
		input logic c);
		logic [8:0] s;
		s = {1'b0, a} + {1'b0, b} + {8'd0, c};
		return {(a[7] ^ s[7]) & (b[7] ^ s[7]), s};
	endfunction

	assign go  = head.valid && (!rsp_valid_q || !rsp_stall);
	assign pop = go;

	always_comb begin
		opnd  = head.item.operand;
		cf    = p_q[cae_pkg::FLAG_C];
		acc_n = acc_q;
		x_n   = x_q;
		y_n   = y_q;
		sp_n  = sp_q;
		p_n   = p_q;
		res   = '0;
		zen   = 1'b0;
		zv    = '0;
		t     = acc_q & opnd;
		r     = '0;
		ad    = add_f(acc_q, opnd, cf);
		br    = head.item.is_branch && (p_q[head.item.br_flag] == head.item.br_pol);
		unique case (head.item.op)
			cae_pkg::OP_LDA: begin acc_n = opnd; zen = 1'b1; zv = opnd; end
			cae_pkg::OP_LDX: begin x_n = opnd; zen = 1'b1; zv = opnd; end
			cae_pkg::OP_LDY: begin y_n = opnd; zen = 1'b1; zv = opnd; end
			cae_pkg::OP_EOR: begin acc_n = acc_q ^ opnd; zen = 1'b1; zv = acc_n; end
			cae_pkg::OP_AND: begin acc_n = t; zen = 1'b1; zv = acc_n; end
			cae_pkg::OP_ORA: begin acc_n = acc_q | opnd; zen = 1'b1; zv = acc_n; end
			cae_pkg::OP_ADC: begin
				acc_n = ad[7:0]; p_n[cae_pkg::FLAG_C] = ad[8];
				p_n[cae_pkg::FLAG_V] = ad[9]; zen = 1'b1; zv = ad[7:0];
			end
			cae_pkg::OP_SBC: begin
				ad = add_f(acc_q, ~opnd, cf);
				acc_n = ad[7:0]; p_n[cae_pkg::FLAG_C] = ad[8];
				p_n[cae_pkg::FLAG_V] = ad[9]; zen = 1'b1; zv = ad[7:0];
			end
			cae_pkg::OP_CMP: begin
				p_n[cae_pkg::FLAG_C] = (acc_q >= opnd); zen = 1'b1; zv = acc_q - opnd;
			end
			cae_pkg::OP_BIT: begin
				p_n[cae_pkg::FLAG_V] = opnd[6];
				p_n[cae_pkg::FLAG_N] = opnd[7];
				p_n[cae_pkg::FLAG_Z] = (t == 8'd0);
			end
			cae_pkg::OP_LAX: begin acc_n = opnd; x_n = opnd; zen = 1'b1; zv = opnd; end
			cae_pkg::OP_NOP: begin end
			cae_pkg::OP_ASL: begin
				res = {opnd[6:0], 1'b0}; p_n[cae_pkg::FLAG_C] = opnd[7]; zen = 1'b1; zv = res;
			end
			cae_pkg::OP_LSR: begin
				res = {1'b0, opnd[7:1]}; p_n[cae_pkg::FLAG_C] = opnd[0]; zen = 1'b1; zv = res;
			end
			cae_pkg::OP_ROL: begin
				res = {opnd[6:0], cf}; p_n[cae_pkg::FLAG_C] = opnd[7]; zen = 1'b1; zv = res;
			end
			cae_pkg::OP_ROR: begin
				res = {cf, opnd[7:1]}; p_n[cae_pkg::FLAG_C] = opnd[0]; zen = 1'b1; zv = res;
			end
			cae_pkg::OP_INC: begin res = opnd + 8'd1; zen = 1'b1; zv = res; end
			cae_pkg::OP_DEC: begin res = opnd - 8'd1; zen = 1'b1; zv = res; end
			cae_pkg::OP_SLO: begin
				res = {opnd[6:0], 1'b0}; p_n[cae_pkg::FLAG_C] = opnd[7];
				acc_n = acc_q | res; zen = 1'b1; zv = acc_n;
			end
			cae_pkg::OP_SRE: begin
				res = {1'b0, opnd[7:1]}; p_n[cae_pkg::FLAG_C] = opnd[0];
				acc_n = acc_q ^ res; zen = 1'b1; zv = acc_n;
			end
			cae_pkg::OP_RLA: begin
				res = {opnd[6:0], cf}; p_n[cae_pkg::FLAG_C] = opnd[7];
				acc_n = acc_q & res; zen = 1'b1; zv = acc_n;
			end
			cae_pkg::OP_RRA: begin
				// add takes the carry that the rotate shifted out
				res = {cf, opnd[7:1]};
				ad = add_f(acc_q, res, opnd[0]);
				acc_n = ad[7:0]; p_n[cae_pkg::FLAG_C] = ad[8];
				p_n[cae_pkg::FLAG_V] = ad[9]; zen = 1'b1; zv = ad[7:0];
			end
			cae_pkg::OP_ISC: begin
				res = opnd + 8'd1;
				ad = add_f(acc_q, ~res, cf);
				acc_n = ad[7:0]; p_n[cae_pkg::FLAG_C] = ad[8];
				p_n[cae_pkg::FLAG_V] = ad[9]; zen = 1'b1; zv = ad[7:0];
			end
			cae_pkg::OP_DCP: begin
				res = opnd - 8'd1;
				p_n[cae_pkg::FLAG_C] = (acc_q >= res); zen = 1'b1; zv = acc_q - res;
			end
			cae_pkg::OP_STA: res = acc_q;
			cae_pkg::OP_STX: res = x_q;
			cae_pkg::OP_STY: res = y_q;
			cae_pkg::OP_SAX: res = acc_q & x_q;
			cae_pkg::OP_BCC, cae_pkg::OP_BCS, cae_pkg::OP_BEQ, cae_pkg::OP_BMI,
			cae_pkg::OP_BNE, cae_pkg::OP_BPL, cae_pkg::OP_BVC, cae_pkg::OP_BVS: begin end
			cae_pkg::OP_ASL_A: begin
				acc_n = {acc_q[6:0], 1'b0}; p_n[cae_pkg::FLAG_C] = acc_q[7];
				zen = 1'b1; zv = acc_n;
			end
			cae_pkg::OP_LSR_A: begin
				acc_n = {1'b0, acc_q[7:1]}; p_n[cae_pkg::FLAG_C] = acc_q[0];
				zen = 1'b1; zv = acc_n;
			end
			cae_pkg::OP_ROL_A: begin
				acc_n = {acc_q[6:0], cf}; p_n[cae_pkg::FLAG_C] = acc_q[7];
				zen = 1'b1; zv = acc_n;
			end
			cae_pkg::OP_ROR_A: begin
				acc_n = {cf, acc_q[7:1]}; p_n[cae_pkg::FLAG_C] = acc_q[0];
				zen = 1'b1; zv = acc_n;
			end
			cae_pkg::OP_CPX: begin
				p_n[cae_pkg::FLAG_C] = (x_q >= opnd); zen = 1'b1; zv = x_q - opnd;
			end
			cae_pkg::OP_CPY: begin
				p_n[cae_pkg::FLAG_C] = (y_q >= opnd); zen = 1'b1; zv = y_q - opnd;
			end
			cae_pkg::OP_CLC: p_n[cae_pkg::FLAG_C] = 1'b0;
			cae_pkg::OP_CLD: p_n[cae_pkg::FLAG_D] = 1'b0;
			cae_pkg::OP_CLI: p_n[cae_pkg::FLAG_I] = 1'b0;
			cae_pkg::OP_CLV: p_n[cae_pkg::FLAG_V] = 1'b0;
			cae_pkg::OP_DEX: begin x_n = x_q - 8'd1; zen = 1'b1; zv = x_n; end
			cae_pkg::OP_DEY: begin y_n = y_q - 8'd1; zen = 1'b1; zv = y_n; end
			cae_pkg::OP_INX: begin x_n = x_q + 8'd1; zen = 1'b1; zv = x_n; end
			cae_pkg::OP_INY: begin y_n = y_q + 8'd1; zen = 1'b1; zv = y_n; end
			cae_pkg::OP_SEC: p_n[cae_pkg::FLAG_C] = 1'b1;
			cae_pkg::OP_SED: p_n[cae_pkg::FLAG_D] = 1'b1;
			cae_pkg::OP_SEI: p_n[cae_pkg::FLAG_I] = 1'b1;
			cae_pkg::OP_TAX: begin x_n = acc_q; zen = 1'b1; zv = acc_q; end
			cae_pkg::OP_TAY: begin y_n = acc_q; zen = 1'b1; zv = acc_q; end
			cae_pkg::OP_TSX: begin x_n = sp_q; zen = 1'b1; zv = sp_q; end
			cae_pkg::OP_TXA: begin acc_n = x_q; zen = 1'b1; zv = x_q; end
			cae_pkg::OP_TYA: begin acc_n = y_q; zen = 1'b1; zv = y_q; end
			cae_pkg::OP_TXS: sp_n = x_q;
			cae_pkg::OP_ALR: begin
				acc_n = {1'b0, t[7:1]}; p_n[cae_pkg::FLAG_C] = t[0]; zen = 1'b1; zv = acc_n;
			end
			cae_pkg::OP_ANC: begin
				acc_n = t; p_n[cae_pkg::FLAG_C] = t[7]; zen = 1'b1; zv = t;
			end
			cae_pkg::OP_ARR: begin
				r = {cf, t[7:1]};
				acc_n = r; zen = 1'b1; zv = r;
				p_n[cae_pkg::FLAG_C] = r[6];
				p_n[cae_pkg::FLAG_V] = r[6] ^ r[5];
			end
			cae_pkg::OP_AXS: begin
				r = acc_q & x_q;
				p_n[cae_pkg::FLAG_C] = (r >= opnd);
				x_n = r - opnd; zen = 1'b1; zv = x_n;
			end
			default: begin end
		endcase
		if (zen) begin
			p_n[cae_pkg::FLAG_Z] = (zv == 8'd0);
			p_n[cae_pkg::FLAG_N] = zv[7];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			x_q         <= '0;
			y_q         <= '0;
			sp_q        <= '0;
			p_q         <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (go) begin
				acc_q <= acc_n;
				x_q   <= x_n;
				y_q   <= y_n;
				sp_q  <= sp_n;
				p_q   <= p_n;
			end
			if (go) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rsp_q.result_byte  <= res;
			rsp_q.branch_taken <= br;
			rsp_q.acc_out      <= acc_n;
			rsp_q.x_out        <= x_n;
			rsp_q.y_out        <= y_n;
			rsp_q.status_out   <= p_n;
			rsp_q.sp_out       <= sp_n;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_unused_bits: assert property (@(posedge clk) disable iff (!arst_n)
		p_q[5:4] == 2'b00)
		else $error("status bits 5:4 written");

	a_regs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(acc_q) && $stable(x_q) && $stable(y_q) && $stable(p_q))
		else $error("register file changed without an item");

	a_branch_nowrite: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && rsp_q.branch_taken |-> rsp_q.result_byte == 8'd0)
		else $error("taken branch with a write-back byte");

	a_rsp_matches_regs: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> rsp_q.acc_out == acc_q && rsp_q.status_out == p_q)
		else $error("result register out of step with state");

endmodule

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// tb: self-checking bench for cpu6502_alu_execute_core
// Drives op/operand items through the cmd channel under random gaps and
// response stalls, runs a cycle-free model of the register file and flags
// alongside, and compares every returned item field by field in order.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cae_pkg::*;

	localparam int IDLE_LIMIT   = 2000;	// cycles with no handshake on either side
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_ITEMS = 620;
	localparam int TAIL_CYCLES  = 8;	// pipeline is two deep, leave some margin

	// one directed row: item plus an optional hand-typed result
	typedef struct packed {
		cmd_t cmd;
		logic typed;
		rsp_t want;
	} stim_row_t;

	localparam rsp_t NO_WANT = '0;

	logic clk;
	logic arst_n;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp;

	// model copy of the CPU registers
	logic [7:0] cpu_a;
	logic [7:0] cpu_x;
	logic [7:0] cpu_y;
	logic [7:0] cpu_sp;
	logic [7:0] cpu_p;

	rsp_t      due_results[$];	// predicted results, oldest first
	stim_row_t dir_rows[$];
	int        fail_count  = 0;
	int        idle_cycles = 0;
	int        stall_left  = 0;
	logic      recv_calm   = 1'b0;
	logic      send_calm   = 1'b0;

	cpu6502_alu_execute_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ------------------------------------------------------------------------
	// ALU model
	// ------------------------------------------------------------------------

	// Z and N always follow the 8-bit result
	function automatic logic [7:0] zn(input logic [7:0] v);
		cpu_p[FLAG_Z] = (v == 8'h00);
		cpu_p[FLAG_N] = v[7];
		return v;
	endfunction

	function automatic logic [7:0] shl(input logic [7:0] v, input logic cin);
		cpu_p[FLAG_C] = v[7];
		return zn({v[6:0], cin});
	endfunction

	function automatic logic [7:0] shr(input logic [7:0] v, input logic cin);
		cpu_p[FLAG_C] = v[0];
		return zn({cin, v[7:1]});
	endfunction

	// binary add with carry in; sbc feeds the inverted operand
	task automatic add_to_acc(input logic [7:0] b);
		logic [8:0] sum;
		sum = cpu_a + b + cpu_p[FLAG_C];
		cpu_p[FLAG_V] = (cpu_a[7] ^ sum[7]) & (b[7] ^ sum[7]);
		cpu_p[FLAG_C] = sum[8];
		cpu_a = zn(sum[7:0]);
	endtask

	task automatic cmp_into(input logic [7:0] r, input logic [7:0] v);
		cpu_p[FLAG_C] = (r >= v);
		void'(zn(r - v));
	endtask

	// apply one accepted item to the model, return what the core should send
	task automatic run_alu_op(input cmd_t c, output rsp_t r);
		logic [7:0] v;
		logic [7:0] res;
		logic [7:0] t;
		logic       br;
		v   = c.operand;
		res = 8'h00;
		br  = 1'b0;
		case (c.operation)
			OP_LDA:   cpu_a = zn(v);
			OP_LDX:   cpu_x = zn(v);
			OP_LDY:   cpu_y = zn(v);
			OP_EOR:   cpu_a = zn(cpu_a ^ v);
			OP_AND:   cpu_a = zn(cpu_a & v);
			OP_ORA:   cpu_a = zn(cpu_a | v);
			OP_ADC:   add_to_acc(v);
			OP_SBC:   add_to_acc(~v);
			OP_CMP:   cmp_into(cpu_a, v);
			OP_BIT: begin
				cpu_p[FLAG_V] = v[6];
				cpu_p[FLAG_N] = v[7];
				cpu_p[FLAG_Z] = ((cpu_a & v) == 8'h00);
			end
			OP_LAX: begin
				cpu_a = zn(v);
				cpu_x = cpu_a;
			end
			OP_ASL:   res = shl(v, 1'b0);
			OP_LSR:   res = shr(v, 1'b0);
			OP_ROL:   res = shl(v, cpu_p[FLAG_C]);
			OP_ROR:   res = shr(v, cpu_p[FLAG_C]);
			OP_INC:   res = zn(v + 8'd1);
			OP_DEC:   res = zn(v - 8'd1);
			// combined ops: second step sees the modified byte
			OP_SLO: begin
				res = shl(v, 1'b0);
				cpu_a = zn(cpu_a | res);
			end
			OP_SRE: begin
				res = shr(v, 1'b0);
				cpu_a = zn(cpu_a ^ res);
			end
			OP_RLA: begin
				res = shl(v, cpu_p[FLAG_C]);
				cpu_a = zn(cpu_a & res);
			end
			OP_RRA: begin
				// add picks up the carry the rotate just produced
				res = shr(v, cpu_p[FLAG_C]);
				add_to_acc(res);
			end
			OP_ISC: begin
				res = v + 8'd1;
				add_to_acc(~res);
			end
			OP_DCP: begin
				res = v - 8'd1;
				cmp_into(cpu_a, res);
			end
			OP_STA:   res = cpu_a;
			OP_STX:   res = cpu_x;
			OP_STY:   res = cpu_y;
			OP_SAX:   res = cpu_a & cpu_x;
			OP_BCC:   br = !cpu_p[FLAG_C];
			OP_BCS:   br = cpu_p[FLAG_C];
			OP_BEQ:   br = cpu_p[FLAG_Z];
			OP_BMI:   br = cpu_p[FLAG_N];
			OP_BNE:   br = !cpu_p[FLAG_Z];
			OP_BPL:   br = !cpu_p[FLAG_N];
			OP_BVC:   br = !cpu_p[FLAG_V];
			OP_BVS:   br = cpu_p[FLAG_V];
			OP_ASL_A: cpu_a = shl(cpu_a, 1'b0);
			OP_LSR_A: cpu_a = shr(cpu_a, 1'b0);
			OP_ROL_A: cpu_a = shl(cpu_a, cpu_p[FLAG_C]);
			OP_ROR_A: cpu_a = shr(cpu_a, cpu_p[FLAG_C]);
			OP_CPX:   cmp_into(cpu_x, v);
			OP_CPY:   cmp_into(cpu_y, v);
			OP_CLC:   cpu_p[FLAG_C] = 1'b0;
			OP_CLD:   cpu_p[FLAG_D] = 1'b0;
			OP_CLI:   cpu_p[FLAG_I] = 1'b0;
			OP_CLV:   cpu_p[FLAG_V] = 1'b0;
			OP_DEX:   cpu_x = zn(cpu_x - 8'd1);
			OP_DEY:   cpu_y = zn(cpu_y - 8'd1);
			OP_INX:   cpu_x = zn(cpu_x + 8'd1);
			OP_INY:   cpu_y = zn(cpu_y + 8'd1);
			OP_SEC:   cpu_p[FLAG_C] = 1'b1;
			OP_SED:   cpu_p[FLAG_D] = 1'b1;
			OP_SEI:   cpu_p[FLAG_I] = 1'b1;
			OP_TAX:   cpu_x = zn(cpu_a);
			OP_TAY:   cpu_y = zn(cpu_a);
			OP_TSX:   cpu_x = zn(cpu_sp);
			OP_TXA:   cpu_a = zn(cpu_x);
			OP_TYA:   cpu_a = zn(cpu_y);
			OP_TXS:   cpu_sp = cpu_x;	// no flag update
			// alr/arr shift the ANDed accumulator
			OP_ALR:   cpu_a = shr(cpu_a & v, 1'b0);
			OP_ANC: begin
				cpu_a = zn(cpu_a & v);
				cpu_p[FLAG_C] = cpu_p[FLAG_N];
			end
			OP_ARR: begin
				t = cpu_a & v;
				cpu_a = zn({cpu_p[FLAG_C], t[7:1]});
				cpu_p[FLAG_C] = cpu_a[6];
				cpu_p[FLAG_V] = cpu_a[6] ^ cpu_a[5];
			end
			OP_AXS: begin
				t = cpu_a & cpu_x;
				cpu_p[FLAG_C] = (t >= v);
				cpu_x = zn(t - v);
			end
			default: ;	// nop and the unused code leave everything alone
		endcase
		r.result_byte  = res;
		r.branch_taken = br;
		r.acc_out      = cpu_a;
		r.x_out        = cpu_x;
		r.y_out        = cpu_y;
		r.status_out   = cpu_p;
		r.sp_out       = cpu_sp;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------------

	// mostly back-to-back, some short gaps, rare long ones
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// lean on the byte edges that move carry, overflow and zero
	function automatic logic [7:0] pick_operand();
		case ($urandom_range(0, 11))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			4:       return 8'h01;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic add_row(input logic [5:0] code, input logic [7:0] opnd,
			input logic typed, input rsp_t want);
		stim_row_t row;
		row.cmd.operation = code;
		row.cmd.operand   = opnd;
		row.typed         = typed;
		row.want          = want;
		dir_rows.push_back(row);
	endtask

	// Called at a rising edge; returns at the edge where the item is taken.
	// valid stays high across back-to-back items, never dropped and raised
	// in the same step.
	task automatic send_item(input cmd_t c, input logic typed, input rsp_t want);
		int   gap;
		rsp_t predicted;
		gap = send_calm ? 0 : pick_gap();
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		run_alu_op(c, predicted);
		due_results.push_back(typed ? want : predicted);
	endtask

	task automatic wait_drained();
		cmd_valid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Response side: random stall with calm stretches
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		int gap;
		if (stall_left > 0) begin
			rsp_stall  <= 1'b1;
			stall_left <= stall_left - 1;
		end else if (recv_calm) begin
			rsp_stall <= 1'b0;
		end else begin
			gap = pick_gap();
			rsp_stall <= (gap > 0);
			if (gap > 0)
				stall_left <= gap - 1;
		end
		if ($urandom_range(0, 299) == 0)
			recv_calm <= !recv_calm;
	end

	// ------------------------------------------------------------------------
	// Result checker: in-order, field by field
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		rsp_t want;
		logic bad;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (due_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$display("[%0t] unexpected item: res=%h br=%b a=%h x=%h y=%h p=%h sp=%h",
						$realtime, rsp.result_byte, rsp.branch_taken, rsp.acc_out,
						rsp.x_out, rsp.y_out, rsp.status_out, rsp.sp_out);
			end else begin
				want = due_results.pop_front();
				bad = (rsp.result_byte !== want.result_byte)
					|| (rsp.branch_taken !== want.branch_taken)
					|| (rsp.acc_out !== want.acc_out)
					|| (rsp.x_out !== want.x_out)
					|| (rsp.y_out !== want.y_out)
					|| (rsp.status_out !== want.status_out)
					|| (rsp.sp_out !== want.sp_out);
				if (bad) begin
					fail_count++;
					if (fail_count <= MAX_REPORTS) begin
						$display("[%0t] mismatch  want: res=%h br=%b a=%h x=%h y=%h p=%h sp=%h",
							$realtime, want.result_byte, want.branch_taken, want.acc_out,
							want.x_out, want.y_out, want.status_out, want.sp_out);
						$display("[%0t]           got:  res=%h br=%b a=%h x=%h y=%h p=%h sp=%h",
							$realtime, rsp.result_byte, rsp.branch_taken, rsp.acc_out,
							rsp.x_out, rsp.y_out, rsp.status_out, rsp.sp_out);
					end
				end
			end
		end
	end

	// watchdog: any handshake on either side counts as progress
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("cpu6502_alu_execute_core verification failed");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin
		cmd_t c;
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		rsp_stall = 1'b0;
		cpu_a     = 8'h00;
		cpu_x     = 8'h00;
		cpu_y     = 8'h00;
		cpu_sp    = 8'h00;
		cpu_p     = 8'h00;

		// Directed rows, starting from the all-zero reset state. The first
		// few results are obvious and typed in; the rest go through the model.
		add_row(OP_NOP, 8'hFF, 1'b1, NO_WANT);
		add_row(OP_CODE_UNUSED, 8'hAA, 1'b1, NO_WANT);	// unused code acts as nop
		add_row(OP_LDA, 8'h80, 1'b1, {8'h00, 1'b0, 8'h80, 8'h00, 8'h00, 8'h80, 8'h00});
		add_row(OP_LDX, 8'h00, 1'b1, {8'h00, 1'b0, 8'h80, 8'h00, 8'h00, 8'h02, 8'h00});
		add_row(OP_LDY, 8'hFF, 1'b1, {8'h00, 1'b0, 8'h80, 8'h00, 8'hFF, 8'h80, 8'h00});
		add_row(OP_ADC, 8'h7F, 1'b0, NO_WANT);	// 80+7F, no carry, no overflow
		add_row(OP_ADC, 8'h01, 1'b0, NO_WANT);	// wraps to zero with carry out
		add_row(OP_SBC, 8'h00, 1'b0, NO_WANT);
		add_row(OP_LDA, 8'h7F, 1'b0, NO_WANT);
		add_row(OP_ADC, 8'h01, 1'b0, NO_WANT);	// signed overflow
		add_row(OP_BVS, 8'h00, 1'b0, NO_WANT);
		add_row(OP_BMI, 8'h00, 1'b0, NO_WANT);
		add_row(OP_CMP, 8'h80, 1'b0, NO_WANT);
		add_row(OP_BIT, 8'hC0, 1'b0, NO_WANT);
		add_row(OP_ASL, 8'h80, 1'b0, NO_WANT);
		add_row(OP_ROR, 8'h01, 1'b0, NO_WANT);
		add_row(OP_INC, 8'hFF, 1'b0, NO_WANT);
		add_row(OP_DEC, 8'h00, 1'b0, NO_WANT);
		add_row(OP_RRA, 8'hFF, 1'b0, NO_WANT);	// rotate carry feeds the add
		add_row(OP_SEC, 8'h00, 1'b0, NO_WANT);
		add_row(OP_ARR, 8'hFF, 1'b0, NO_WANT);	// C in at bit 7, C/V from bits 6,5
		add_row(OP_ALR, 8'h81, 1'b0, NO_WANT);
		add_row(OP_ANC, 8'h80, 1'b0, NO_WANT);
		add_row(OP_AXS, 8'hFF, 1'b0, NO_WANT);
		add_row(OP_TXS, 8'h00, 1'b0, NO_WANT);
		add_row(OP_TSX, 8'h00, 1'b0, NO_WANT);
		add_row(OP_SAX, 8'h00, 1'b0, NO_WANT);
		add_row(OP_STY, 8'h00, 1'b0, NO_WANT);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_item(dir_rows[i].cmd, dir_rows[i].typed, dir_rows[i].want);

		// hold off until the pipe is empty before the sweep
		wait_drained();

		// every code once, unused one included, random operand
		for (int code = 0; code < 64; code++) begin
			c.operation = 6'(code);
			c.operand   = pick_operand();
			send_item(c, 1'b0, NO_WANT);
		end

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS / 2)
				wait_drained();
			send_calm   = ((i / 80) % 3 == 2);
			c.operation = 6'($urandom_range(0, 63));
			c.operand   = pick_operand();
			send_item(c, 1'b0, NO_WANT);
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("cpu6502_alu_execute_core verification clean");
		else
			$display("cpu6502_alu_execute_core verification failed");
		$finish;
	end

endmodule
